@@ rtl/core/hbt_pkg.sv @@
// shared types and codes of the hpack header block tokenizer
package hbt_pkg;

   localparam int VALUE_W = 64;

   // result event codes
   localparam logic [2:0] EV_INDEXED     = 3'd0;
   localparam logic [2:0] EV_LITERAL     = 3'd1;
   localparam logic [2:0] EV_STR_START   = 3'd2;
   localparam logic [2:0] EV_STR_BYTE    = 3'd3;
   localparam logic [2:0] EV_SIZE_UPDATE = 3'd4;
   localparam logic [2:0] EV_ERROR       = 3'd5;
   localparam logic [2:0] EV_BLOCK_DONE  = 3'd6;

   // representation kinds
   localparam logic [1:0] REPR_INDEXED   = 2'd0;
   localparam logic [1:0] REPR_INCREMENT = 2'd1;
   localparam logic [1:0] REPR_WITHOUT   = 2'd2;
   localparam logic [1:0] REPR_NEVER     = 2'd3;

   // error codes
   localparam logic [1:0] ERR_TRUNCATED   = 2'd0;
   localparam logic [1:0] ERR_INDEX       = 2'd1;
   localparam logic [1:0] ERR_COMPRESSION = 2'd2;
   localparam logic [1:0] ERR_OVERFLOW    = 2'd3;

   // prefix masks of the integer encodings
   localparam logic [7:0] MASK7 = 8'h7F;
   localparam logic [7:0] MASK6 = 8'h3F;
   localparam logic [7:0] MASK5 = 8'h1F;
   localparam logic [7:0] MASK4 = 8'h0F;

   // last shift that may still take another continuation byte
   localparam logic [6:0] SHIFT_LAST = 7'd63;
   localparam logic [6:0] SHIFT_STEP = 7'd7;

   localparam logic [31:0] LIMIT_RESET = 32'd4096;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_IDX_CONT,
      PH_NAMEIDX_CONT,
      PH_LEN_FIRST,
      PH_LEN_CONT,
      PH_STR,
      PH_SIZE_CONT
   } hbt_phase_type;

   typedef struct packed {
      logic [2:0]         event_res;
      logic [1:0]         repr_kind;
      logic [VALUE_W-1:0] value;
      logic               huffman;
      logic               in_value_string;
      logic [7:0]         out_byte;
      logic [1:0]         error_code;
   } hbt_result_type;

   // all results caused by one request byte
   typedef struct packed {
      hbt_result_type primary;
      logic           has_primary;
      logic           has_trunc;
      logic           has_done;
   } hbt_entry_type;

endpackage

@@ rtl/core/hbt_front.sv @@
// front end: classifies bytes, decodes prefix integers, builds result entries
module hbt_front import hbt_pkg::*; #(
   parameter int INT_BITS = 64
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_write_enable,
   input  logic [31:0]   csr_write_data,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [7:0]    req_data_byte,
   input  logic          req_block_end,
   output logic          push_valid,
   input  logic          push_ready,
   output hbt_entry_type push_entry
);

   hbt_phase_type       phase_ff, phase_in, phase_mid;
   logic [INT_BITS-1:0] accum_ff, accum_in;
   logic [6:0]          shift_ff, shift_in;
   logic [1:0]          cur_repr_ff, cur_repr_in;
   logic [INT_BITS-1:0] string_left_ff, string_left_in;
   logic                string_is_value_ff, string_is_value_in;
   logic                header_seen_ff, header_seen_in;
   logic                discarding_ff, discarding_in;
   logic                str_huff_ff, str_huff_in;
   logic [31:0]         limit_ff;

   logic                accept;
   logic [1:0]          kind_now;
   logic                huff_now;
   logic                start_hit, start_full;
   logic [7:0]          start_mask, start_v;
   hbt_phase_type       start_purpose;
   logic                more_hit, more_fail, more_ovf;
   logic [6:0]          more_b;
   logic [INT_BITS+6:0] more_wide;
   logic [INT_BITS:0]   more_sum;
   logic                done_hit;
   logic [INT_BITS-1:0] done_v;
   hbt_phase_type       done_purpose;
   logic                str_hit, str_last;
   logic                after_string;
   logic                fail_hit;
   logic [1:0]          fail_code;
   logic                has_any;

   assign accept     = req_valid && push_ready;
   assign req_ready  = push_ready;
   assign str_last   = string_left_ff == INT_BITS'(1);

   // decode of the current byte against the phase
   always_comb begin
      kind_now      = cur_repr_ff;
      huff_now      = str_huff_ff;
      start_hit     = 1'b0;
      start_mask    = MASK7;
      start_purpose = PH_IDX_CONT;
      more_hit      = 1'b0;
      str_hit       = 1'b0;
      if (!discarding_ff) begin
         unique case (phase_ff)
            PH_IDLE: begin
               start_hit = 1'b1;
               priority if (req_data_byte[7]) begin
                  start_mask    = MASK7;
                  start_purpose = PH_IDX_CONT;
                  kind_now      = REPR_INDEXED;
               end else if (req_data_byte[6]) begin
                  start_mask    = MASK6;
                  start_purpose = PH_NAMEIDX_CONT;
                  kind_now      = REPR_INCREMENT;
               end else if (req_data_byte[5]) begin
                  start_mask    = MASK5;
                  start_purpose = PH_SIZE_CONT;
                  kind_now      = REPR_INDEXED;
               end else if (req_data_byte[4]) begin
                  start_mask    = MASK4;
                  start_purpose = PH_NAMEIDX_CONT;
                  kind_now      = REPR_NEVER;
               end else begin
                  start_mask    = MASK4;
                  start_purpose = PH_NAMEIDX_CONT;
                  kind_now      = REPR_WITHOUT;
               end
            end
            PH_LEN_FIRST: begin
               start_hit     = 1'b1;
               start_mask    = MASK7;
               start_purpose = PH_LEN_CONT;
               huff_now      = req_data_byte[7];
            end
            PH_STR: begin
               str_hit = 1'b1;
            end
            PH_IDX_CONT, PH_NAMEIDX_CONT, PH_LEN_CONT, PH_SIZE_CONT: begin
               more_hit = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // prefix integer: first byte and continuation bytes
   always_comb begin
      start_v    = req_data_byte & start_mask;
      start_full = start_v == start_mask;
      more_b     = req_data_byte[6:0];
      more_wide  = (INT_BITS+7)'(more_b) << shift_ff;
      more_sum   = {1'b0, accum_ff} + {1'b0, more_wide[INT_BITS-1:0]};
      if (shift_ff >= 7'(INT_BITS)) begin
         more_ovf = more_b != 7'd0;
      end else begin
         more_ovf = more_wide[INT_BITS+6:INT_BITS] != 7'd0;
      end
      more_fail = more_hit && (more_ovf || more_sum[INT_BITS] || (shift_ff > SHIFT_LAST));

      done_hit     = 1'b0;
      done_v       = '0;
      done_purpose = start_purpose;
      if (start_hit && !start_full) begin
         done_hit     = 1'b1;
         done_v       = INT_BITS'(start_v);
         done_purpose = start_purpose;
      end else if (more_hit && !more_fail && !req_data_byte[7]) begin
         done_hit     = 1'b1;
         done_v       = more_sum[INT_BITS-1:0];
         done_purpose = phase_ff;
      end

      // errors raised by this byte
      fail_hit  = 1'b0;
      fail_code = ERR_OVERFLOW;
      if (more_fail) begin
         fail_hit  = 1'b1;
         fail_code = ERR_OVERFLOW;
      end else if (done_hit && done_purpose == PH_IDX_CONT && done_v == '0) begin
         fail_hit  = 1'b1;
         fail_code = ERR_INDEX;
      end else if (done_hit && done_purpose == PH_SIZE_CONT &&
                   (header_seen_ff || done_v > INT_BITS'(limit_ff))) begin
         fail_hit  = 1'b1;
         fail_code = ERR_COMPRESSION;
      end
   end

   // phase after the byte, before the block end is applied
   always_comb begin
      after_string = 1'b0;
      phase_mid    = phase_ff;
      if (!discarding_ff) begin
         priority if (fail_hit) begin
            phase_mid = PH_IDLE;
         end else if (done_hit) begin
            case (done_purpose)
               PH_IDX_CONT:     phase_mid = PH_IDLE;
               PH_NAMEIDX_CONT: phase_mid = PH_LEN_FIRST;
               PH_LEN_CONT: begin
                  if (done_v == '0) begin
                     after_string = 1'b1;
                     phase_mid    = string_is_value_ff ? PH_IDLE : PH_LEN_FIRST;
                  end else begin
                     phase_mid = PH_STR;
                  end
               end
               default:         phase_mid = PH_IDLE;
            endcase
         end else if (start_hit) begin
            phase_mid = start_purpose;
         end else if (str_hit) begin
            if (str_last) begin
               after_string = 1'b1;
               phase_mid    = string_is_value_ff ? PH_IDLE : PH_LEN_FIRST;
            end
         end else if (!more_hit) begin
            phase_mid = PH_IDLE;
         end
      end
   end

   // next state
   always_comb begin
      phase_in           = phase_mid;
      discarding_in      = discarding_ff || fail_hit;
      cur_repr_in        = kind_now;
      str_huff_in        = huff_now;
      accum_in           = accum_ff;
      shift_in           = shift_ff;
      string_left_in     = string_left_ff;
      string_is_value_in = string_is_value_ff;
      header_seen_in     = header_seen_ff;
      if (start_hit && start_full) begin
         accum_in = INT_BITS'(start_v);
         shift_in = '0;
      end else if (more_hit && !more_fail) begin
         accum_in = more_sum[INT_BITS-1:0];
         shift_in = shift_ff + SHIFT_STEP;
      end
      if (done_hit && done_purpose == PH_LEN_CONT && done_v != '0) begin
         string_left_in = done_v;
      end else if (str_hit) begin
         string_left_in = string_left_ff - INT_BITS'(1);
      end
      if (done_hit && done_purpose == PH_NAMEIDX_CONT) begin
         string_is_value_in = done_v != '0;
      end else if (after_string) begin
         string_is_value_in = 1'b1;
      end
      if (done_hit && !fail_hit &&
          (done_purpose == PH_IDX_CONT || done_purpose == PH_NAMEIDX_CONT)) begin
         header_seen_in = 1'b1;
      end
      if (req_block_end) begin
         phase_in           = PH_IDLE;
         discarding_in      = 1'b0;
         header_seen_in     = 1'b0;
         string_is_value_in = 1'b0;
         string_left_in     = '0;
         accum_in           = '0;
         shift_in           = '0;
      end
   end

   // result entry for this byte
   always_comb begin
      push_entry = '0;
      push_entry.has_primary = fail_hit || done_hit || str_hit;
      if (fail_hit) begin
         push_entry.primary.event_res  = EV_ERROR;
         push_entry.primary.error_code = fail_code;
      end else if (str_hit) begin
         push_entry.primary.event_res       = EV_STR_BYTE;
         push_entry.primary.repr_kind       = cur_repr_ff;
         push_entry.primary.in_value_string = string_is_value_ff;
         push_entry.primary.out_byte        = req_data_byte;
      end else if (done_hit) begin
         push_entry.primary.value = VALUE_W'(done_v);
         case (done_purpose)
            PH_IDX_CONT: begin
               push_entry.primary.event_res = EV_INDEXED;
            end
            PH_NAMEIDX_CONT: begin
               push_entry.primary.event_res = EV_LITERAL;
               push_entry.primary.repr_kind = kind_now;
            end
            PH_LEN_CONT: begin
               push_entry.primary.event_res       = EV_STR_START;
               push_entry.primary.repr_kind       = cur_repr_ff;
               push_entry.primary.huffman         = huff_now;
               push_entry.primary.in_value_string = string_is_value_ff;
            end
            default: begin
               push_entry.primary.event_res = EV_SIZE_UPDATE;
            end
         endcase
      end
      push_entry.has_trunc = req_block_end && !(discarding_ff || fail_hit) &&
                             phase_mid != PH_IDLE;
      push_entry.has_done  = req_block_end;
   end

   assign has_any    = push_entry.has_primary || req_block_end;
   assign push_valid = accept && has_any;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= PH_IDLE;
         discarding_ff      <= 1'b0;
         header_seen_ff     <= 1'b0;
         string_is_value_ff <= 1'b0;
         string_left_ff     <= '0;
         accum_ff           <= '0;
         shift_ff           <= '0;
         cur_repr_ff        <= REPR_INDEXED;
         str_huff_ff        <= 1'b0;
      end else if (accept) begin
         phase_ff           <= phase_in;
         discarding_ff      <= discarding_in;
         header_seen_ff     <= header_seen_in;
         string_is_value_ff <= string_is_value_in;
         string_left_ff     <= string_left_in;
         accum_ff           <= accum_in;
         shift_ff           <= shift_in;
         cur_repr_ff        <= cur_repr_in;
         str_huff_ff        <= str_huff_in;
      end
   end

   // size update limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_write_enable) begin
         limit_ff <= csr_write_data;
      end
   end

endmodule

@@ rtl/core/hbt_queue.sv @@
// short register queue of result entries between front and back end
module hbt_queue import hbt_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   output logic          push_ready,
   input  hbt_entry_type push_entry,
   output logic          pop_valid,
   input  logic          pop_ready,
   output hbt_entry_type pop_entry
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   hbt_entry_type    slot_ff [DEPTH];
   logic [PTR_W-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_entry  = slot_ff[head_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // pointer and fill bookkeeping
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (do_push) begin
         tail_in = (tail_ff == PTR_W'(DEPTH - 1)) ? '0 : tail_ff + PTR_W'(1);
      end
      if (do_pop) begin
         head_in = (head_ff == PTR_W'(DEPTH - 1)) ? '0 : head_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[tail_ff] <= push_entry;
      end
   end

endmodule

@@ rtl/core/hbt_back.sv @@
// back end: unpacks queue entries into single results on the response channel
module hbt_back import hbt_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          pop_valid,
   output logic          pop_ready,
   input  hbt_entry_type pop_entry,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [2:0]    rsp_event_res,
   output logic [1:0]    rsp_repr_kind,
   output logic [63:0]   rsp_value,
   output logic          rsp_huffman,
   output logic          rsp_in_value_string,
   output logic [7:0]    rsp_out_byte,
   output logic [1:0]    rsp_error_code,
   output logic          rsp_last
);

   logic [2:0]     consumed_ff, consumed_in;
   logic [2:0]     pending, sel;
   logic           sel_last, load;
   hbt_result_type cur;
   hbt_result_type result_ff, result_in;
   logic           valid_ff, valid_in;
   logic           last_ff, last_in;

   // pick the next result of the head entry in order
   always_comb begin
      pending = {pop_entry.has_done, pop_entry.has_trunc, pop_entry.has_primary} &
                ~consumed_ff;
      priority if (pending[0]) begin
         sel = 3'b001;
      end else if (pending[1]) begin
         sel = 3'b010;
      end else begin
         sel = 3'b100;
      end
      sel_last = (pending & ~sel) == 3'b000;
      cur = '0;
      if (sel[0]) begin
         cur = pop_entry.primary;
      end else if (sel[1]) begin
         cur.event_res  = EV_ERROR;
         cur.error_code = ERR_TRUNCATED;
      end else begin
         cur.event_res = EV_BLOCK_DONE;
      end
   end

   assign load      = !valid_ff || rsp_ready;
   assign pop_ready = load && sel_last;

   // output register load
   always_comb begin
      result_in   = result_ff;
      last_in     = last_ff;
      valid_in    = valid_ff;
      consumed_in = consumed_ff;
      if (load) begin
         valid_in = pop_valid;
         if (pop_valid) begin
            result_in   = cur;
            last_in     = sel_last;
            consumed_in = sel_last ? 3'b000 : (consumed_ff | sel);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         consumed_ff <= 3'b000;
      end else begin
         valid_ff    <= valid_in;
         consumed_ff <= consumed_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
      last_ff   <= last_in;
   end

   assign rsp_valid           = valid_ff;
   assign rsp_event_res       = result_ff.event_res;
   assign rsp_repr_kind       = result_ff.repr_kind;
   assign rsp_value           = result_ff.value;
   assign rsp_huffman         = result_ff.huffman;
   assign rsp_in_value_string = result_ff.in_value_string;
   assign rsp_out_byte        = result_ff.out_byte;
   assign rsp_error_code      = result_ff.error_code;
   assign rsp_last            = last_ff;

endmodule

@@ rtl/core/hpack_block_tokenizer_unit.sv @@
// top level of the hpack header block tokenizer
//
// Header block bytes enter on the req_ channel, one byte per request, with
// req_block_end marking the last byte of a block. Each request yields zero to
// three results on the rsp_ channel (field events, string bytes, size
// updates, errors, block done); rsp_last marks the last result of a request.
// csr_write_enable/csr_write_data set the size update limit (4096 at reset).
// The results of a request pass through the entry queue slot and then the response register.
// Throughput: one request per cycle while each byte yields at most one
// result; the response register sends one result per cycle, so a byte with
// two or three results holds the output until all of them are sent, and the entry
// queue (QUEUE_DEPTH requests deep) absorbs the difference.
// When the receiver stalls, results wait in the response register and the
// queue; once the queue is full req_ready drops until space frees up.
// Reset (synchronous) empties the queue and output, returns the decoder to
// the start of a block and loads the default limit.
module hpack_block_tokenizer_unit import hbt_pkg::*; #(
   parameter int INT_BITS    = 64,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_block_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_event_res,
   output logic [1:0]  rsp_repr_kind,
   output logic [63:0] rsp_value,
   output logic        rsp_huffman,
   output logic        rsp_in_value_string,
   output logic [7:0]  rsp_out_byte,
   output logic [1:0]  rsp_error_code,
   output logic        rsp_last
);

   logic          push_valid, push_ready;
   hbt_entry_type push_entry;
   logic          pop_valid, pop_ready;
   hbt_entry_type pop_entry;

   // byte classification and integer decoding
   hbt_front #(
      .INT_BITS (INT_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_block_end    (req_block_end),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_entry       (push_entry)
   );

   // entry queue
   hbt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   // result serializer
   hbt_back u_back (
      .clock               (clock),
      .reset               (reset),
      .pop_valid           (pop_valid),
      .pop_ready           (pop_ready),
      .pop_entry           (pop_entry),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_event_res       (rsp_event_res),
      .rsp_repr_kind       (rsp_repr_kind),
      .rsp_value           (rsp_value),
      .rsp_huffman         (rsp_huffman),
      .rsp_in_value_string (rsp_in_value_string),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_error_code      (rsp_error_code),
      .rsp_last            (rsp_last)
   );

endmodule

@@ test/hpack_block_tokenizer_unit_tb.sv @@
// self-checking testbench of the hpack header block tokenizer top level
module hpack_block_tokenizer_unit_tb;
   import hbt_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // first-byte patterns of the field representations
   localparam logic [7:0] PAT_INDEXED   = 8'h80;
   localparam logic [7:0] PAT_INCREMENT = 8'h40;
   localparam logic [7:0] PAT_SIZE      = 8'h20;
   localparam logic [7:0] PAT_NEVER     = 8'h10;
   localparam logic [7:0] PAT_WITHOUT   = 8'h00;

   // prefix integer width and the shift past which continuation bytes overflow
   localparam int unsigned INT_W     = 64;
   localparam int unsigned SHIFT_CAP = 70;

   localparam int unsigned LONG_HOLD  = 300;
   localparam int unsigned DRAIN_GAP  = 6;
   localparam int unsigned END_GAP    = 10;
   localparam int unsigned END_SPINS  = 20000;

   typedef struct packed {
      hbt_result_type r;
      logic           last;
   } token_type;

   // directed request with an optional hand-written first result
   typedef struct packed {
      logic [7:0]  data;
      logic        blk_end;
      logic        typed;
      logic [2:0]  ev;
      logic [63:0] val;
      logic [1:0]  err;
   } dir_row_type;

   localparam int DIR_N = 23;
   localparam dir_row_type DIR_ROWS [0:DIR_N-1] = '{
      // indexed field right after reset, then index zero
      '{8'h82, 1'b0, 1'b1, EV_INDEXED,     64'd2, '0},
      '{8'h80, 1'b1, 1'b1, EV_ERROR,       '0,    ERR_INDEX},
      // two size updates at block start, the second one at the limit
      '{8'h20, 1'b0, 1'b1, EV_SIZE_UPDATE, '0,    '0},
      '{8'h3F, 1'b0, 1'b0, '0, '0, '0},
      '{8'hE1, 1'b0, 1'b0, '0, '0, '0},
      '{8'h1F, 1'b0, 1'b0, '0, '0, '0},
      // incremental literal, indexed name, huffman value of three bytes
      '{8'h44, 1'b0, 1'b0, '0, '0, '0},
      '{8'h83, 1'b0, 1'b0, '0, '0, '0},
      '{8'h00, 1'b0, 1'b0, '0, '0, '0},
      '{8'hFF, 1'b0, 1'b0, '0, '0, '0},
      '{8'h5A, 1'b0, 1'b0, '0, '0, '0},
      // literal without indexing, literal name, empty value
      '{8'h00, 1'b0, 1'b0, '0, '0, '0},
      '{8'h01, 1'b0, 1'b0, '0, '0, '0},
      '{8'hA5, 1'b0, 1'b0, '0, '0, '0},
      '{8'h00, 1'b0, 1'b0, '0, '0, '0},
      // never indexed literal, block ends inside the value length
      '{8'h1F, 1'b0, 1'b0, '0, '0, '0},
      '{8'h00, 1'b0, 1'b0, '0, '0, '0},
      '{8'h7F, 1'b1, 1'b1, EV_ERROR,       '0,    ERR_TRUNCATED},
      // size update after a header
      '{8'h82, 1'b0, 1'b0, '0, '0, '0},
      '{8'h21, 1'b1, 1'b1, EV_ERROR,       '0,    ERR_COMPRESSION},
      // size update one above the limit
      '{8'h3F, 1'b0, 1'b0, '0, '0, '0},
      '{8'hE2, 1'b0, 1'b0, '0, '0, '0},
      '{8'h1F, 1'b1, 1'b1, EV_ERROR,       '0,    ERR_COMPRESSION}
   };

   logic        clock;
   logic        reset               = 1'b1;
   logic        csr_write_enable    = 1'b0;
   logic [31:0] csr_write_data      = '0;
   logic        req_valid           = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte       = '0;
   logic        req_block_end       = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready           = 1'b0;
   logic [2:0]  rsp_event_res;
   logic [1:0]  rsp_repr_kind;
   logic [63:0] rsp_value;
   logic        rsp_huffman;
   logic        rsp_in_value_string;
   logic [7:0]  rsp_out_byte;
   logic [1:0]  rsp_error_code;
   logic        rsp_last;

   hpack_block_tokenizer_unit u_dut (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_data_byte       (req_data_byte),
      .req_block_end       (req_block_end),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_event_res       (rsp_event_res),
      .rsp_repr_kind       (rsp_repr_kind),
      .rsp_value           (rsp_value),
      .rsp_huffman         (rsp_huffman),
      .rsp_in_value_string (rsp_in_value_string),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_error_code      (rsp_error_code),
      .rsp_last            (rsp_last)
   );

   // tokenizer state as the block should hold it
   logic [31:0]   limit_q    = LIMIT_RESET;
   hbt_phase_type ph_q       = PH_IDLE;
   logic [63:0]   accum_q    = '0;
   int unsigned   shift_q    = 0;
   logic [1:0]    repr_q     = REPR_INDEXED;
   logic [63:0]   str_left_q = '0;
   logic          str_val_q  = 1'b0;
   logic          hdr_seen_q = 1'b0;
   logic          discard_q  = 1'b0;
   logic          huff_q     = 1'b0;

   token_type   step_toks[$];
   token_type   expected_tokens[$];
   logic [7:0]  blk_bytes[$];
   token_type   want;
   int unsigned mismatches     = 0;
   int unsigned items_counted  = 0;
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned hold_req       = 0;
   int unsigned hold_ack       = 0;
   int unsigned hold_left      = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #400000;
      $display("FAILURE");
      $finish;
   end

   // ---------------------------------------------------------------- tokenizer

   function automatic void push_tok(logic [2:0] ev, logic [1:0] kind, logic [63:0] val,
                                    logic huff, logic isv, logic [7:0] b, logic [1:0] err);
      token_type t;
      if (step_toks.size() >= 3) return;
      t.r.event_res       = ev;
      t.r.repr_kind       = kind;
      t.r.value           = val;
      t.r.huffman         = huff;
      t.r.in_value_string = isv;
      t.r.out_byte        = b;
      t.r.error_code      = err;
      t.last              = 1'b0;
      step_toks.insert(step_toks.size(), t);
   endfunction

   function automatic void raise_error(logic [1:0] code);
      push_tok(EV_ERROR, '0, '0, 1'b0, 1'b0, '0, code);
      discard_q = 1'b1;
      ph_q      = PH_IDLE;
   endfunction

   // name string done moves on to the value, value string ends the field
   function automatic void string_done();
      if (!str_val_q) begin
         str_val_q = 1'b1;
         ph_q      = PH_LEN_FIRST;
      end else begin
         ph_q = PH_IDLE;
      end
   endfunction

   function automatic void finish_int(logic [63:0] v, hbt_phase_type purpose);
      case (purpose)
         PH_IDX_CONT: begin
            if (v == 0) begin
               raise_error(ERR_INDEX);
            end else begin
               push_tok(EV_INDEXED, REPR_INDEXED, v, 1'b0, 1'b0, '0, '0);
               hdr_seen_q = 1'b1;
               ph_q       = PH_IDLE;
            end
         end
         PH_NAMEIDX_CONT: begin
            push_tok(EV_LITERAL, repr_q, v, 1'b0, 1'b0, '0, '0);
            hdr_seen_q = 1'b1;
            str_val_q  = (v != 0);
            ph_q       = PH_LEN_FIRST;
         end
         PH_LEN_CONT: begin
            push_tok(EV_STR_START, repr_q, v, huff_q, str_val_q, '0, '0);
            if (v == 0) begin
               string_done();
            end else begin
               str_left_q = v;
               ph_q       = PH_STR;
            end
         end
         default: begin
            if (hdr_seen_q || v > 64'(limit_q)) begin
               raise_error(ERR_COMPRESSION);
            end else begin
               push_tok(EV_SIZE_UPDATE, '0, v, 1'b0, 1'b0, '0, '0);
               ph_q = PH_IDLE;
            end
         end
      endcase
   endfunction

   function automatic void start_int(logic [7:0] b, int bits, hbt_phase_type purpose);
      logic [7:0] mask;
      mask = 8'((1 << bits) - 1);
      if ((b & mask) < mask) begin
         finish_int(64'(b & mask), purpose);
      end else begin
         accum_q = 64'(mask);
         shift_q = 0;
         ph_q    = purpose;
      end
   endfunction

   // one continuation byte of a prefix integer
   function automatic void more_int(logic [7:0] b);
      logic [6:0]  low7;
      logic [63:0] add;
      int unsigned room;
      low7 = b[6:0];
      add  = '0;
      if (shift_q >= INT_W) begin
         if (low7 != 0) begin
            raise_error(ERR_OVERFLOW);
            return;
         end
      end else begin
         room = INT_W - shift_q;
         if (room < 7 && (low7 >> room) != 0) begin
            raise_error(ERR_OVERFLOW);
            return;
         end
         add = 64'(low7) << shift_q;
         // sum must stay within the 64-bit range
         if (add > ~accum_q) begin
            raise_error(ERR_OVERFLOW);
            return;
         end
      end
      accum_q = accum_q + add;
      if (shift_q + 7 > SHIFT_CAP) begin
         raise_error(ERR_OVERFLOW);
         return;
      end
      shift_q = shift_q + 7;
      if (!b[7]) finish_int(accum_q, ph_q);
   endfunction

   // results of one request byte land in step_toks; returns 0 for a discarded byte
   function automatic bit tokenize_byte(logic [7:0] b, logic e);
      bit active;
      step_toks.delete();
      active = !discard_q;
      if (!discard_q) begin
         case (ph_q)
            PH_IDLE: begin
               if (b[7]) begin
                  repr_q = REPR_INDEXED;
                  start_int(b, 7, PH_IDX_CONT);
               end else if (b[6]) begin
                  repr_q = REPR_INCREMENT;
                  start_int(b, 6, PH_NAMEIDX_CONT);
               end else if (b[5]) begin
                  repr_q = REPR_INDEXED;
                  start_int(b, 5, PH_SIZE_CONT);
               end else if (b[4]) begin
                  repr_q = REPR_NEVER;
                  start_int(b, 4, PH_NAMEIDX_CONT);
               end else begin
                  repr_q = REPR_WITHOUT;
                  start_int(b, 4, PH_NAMEIDX_CONT);
               end
            end
            PH_LEN_FIRST: begin
               huff_q = b[7];
               start_int(b, 7, PH_LEN_CONT);
            end
            PH_STR: begin
               push_tok(EV_STR_BYTE, repr_q, '0, 1'b0, str_val_q, b, '0);
               str_left_q = str_left_q - 1;
               if (str_left_q == 0) string_done();
            end
            default: more_int(b);
         endcase
      end
      // block end: truncation check, block done, fresh block state
      if (e) begin
         if (!discard_q && ph_q != PH_IDLE)
            push_tok(EV_ERROR, '0, '0, 1'b0, 1'b0, '0, ERR_TRUNCATED);
         push_tok(EV_BLOCK_DONE, '0, '0, 1'b0, 1'b0, '0, '0);
         ph_q       = PH_IDLE;
         discard_q  = 1'b0;
         hdr_seen_q = 1'b0;
         str_val_q  = 1'b0;
         str_left_q = '0;
         accum_q    = '0;
         shift_q    = 0;
      end
      if (step_toks.size() > 0) step_toks[step_toks.size()-1].last = 1'b1;
      return active;
   endfunction

   // ---------------------------------------------------------------- block builder

   function automatic void add_int(int bits, logic [7:0] pattern, logic [63:0] v);
      logic [7:0]  mask;
      logic [63:0] rest;
      mask = 8'((1 << bits) - 1);
      if (v < 64'(mask)) begin
         blk_bytes.insert(blk_bytes.size(), pattern | 8'(v));
      end else begin
         blk_bytes.insert(blk_bytes.size(), pattern | mask);
         rest = v - 64'(mask);
         while (rest >= 128) begin
            blk_bytes.insert(blk_bytes.size(), {1'b1, rest[6:0]});
            rest = rest >> 7;
         end
         blk_bytes.insert(blk_bytes.size(), {1'b0, rest[6:0]});
      end
   endfunction

   function automatic logic [63:0] pick_number(bit allow_zero);
      case ($urandom_range(0, 9))
         0:       return allow_zero ? 64'd0 : 64'd1;
         1:       return {$urandom, $urandom};
         2:       return '1;
         3:       return 64'($urandom_range(100, 20000));
         default: return 64'($urandom_range(1, 126));
      endcase
   endfunction

   function automatic logic [63:0] pick_size();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return 64'(limit_q);
         2:       return 64'(limit_q) + 1;
         3:       return 64'($urandom);
         4:       return {$urandom, $urandom};
         default: return 64'($urandom_range(0, 5000));
      endcase
   endfunction

   function automatic void add_string();
      int unsigned len;
      len = $urandom_range(0, 5);
      add_int(7, {1'($urandom_range(0, 1)), 7'b0}, 64'(len));
      repeat (len) blk_bytes.insert(blk_bytes.size(), 8'($urandom));
   endfunction

   function automatic void add_field();
      int unsigned pick;
      logic [63:0] name_idx;
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
         add_int(7, PAT_INDEXED, pick_number(1'b1));
      end else begin
         name_idx = ($urandom_range(0, 2) == 0) ? 64'd0 : pick_number(1'b0);
         case (pick % 3)
            0:       add_int(6, PAT_INCREMENT, name_idx);
            1:       add_int(4, PAT_WITHOUT, name_idx);
            default: add_int(4, PAT_NEVER, name_idx);
         endcase
         if (name_idx == 0) add_string();
         add_string();
      end
   endfunction

   // mostly well-formed blocks, some with an overflow, a late update, a cut or only random bytes
   function automatic void build_block();
      int unsigned flavor;
      int unsigned cut;
      blk_bytes.delete();
      flavor = $urandom_range(0, 15);
      if (flavor == 0) begin
         repeat ($urandom_range(1, 6)) blk_bytes.insert(blk_bytes.size(), 8'($urandom));
         return;
      end
      if ($urandom_range(0, 2) == 0) add_int(5, PAT_SIZE, pick_size());
      repeat ($urandom_range(1, 3)) add_field();
      if (flavor == 1) begin
         blk_bytes.insert(blk_bytes.size(), 8'hFF);
         repeat ($urandom_range(9, 11))
            blk_bytes.insert(blk_bytes.size(), 8'($urandom) | 8'h80);
         blk_bytes.insert(blk_bytes.size(), 8'($urandom));
      end
      if (flavor == 2) add_int(5, PAT_SIZE, pick_size());
      if (flavor == 3) begin
         cut = $urandom_range(1, blk_bytes.size());
         while (blk_bytes.size() > cut) blk_bytes.delete(blk_bytes.size() - 1);
      end
   endfunction

   // ---------------------------------------------------------------- drivers

   task automatic send_req(input logic [7:0] b, input logic e, input bit keep);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_block_end <= e;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      void'(tokenize_byte(b, e));
      items_counted++;
      if (keep)
         foreach (step_toks[i]) expected_tokens.insert(expected_tokens.size(), step_toks[i]);
   endtask

   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (DRAIN_GAP) @(posedge clock);
   endtask

   task automatic load_limit(input logic [31:0] v);
      drain_pipeline();
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      limit_q = v;
   endtask

   task automatic run_random(input int unsigned n);
      int unsigned target;
      target = items_counted + n;
      while (items_counted < target) begin
         build_block();
         foreach (blk_bytes[i]) send_req(blk_bytes[i], i == blk_bytes.size() - 1, 1'b1);
      end
   endtask

   // receiver: random stalls plus a long hold-off each time one is requested
   always @(posedge clock) begin
      if (hold_req != hold_ack) begin
         hold_ack  = hold_req;
         hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // ---------------------------------------------------------------- checker

   function automatic void check_field(string what, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp_v, act_v);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_tokens.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual event %0d value %0h",
                     $time, rsp_event_res, rsp_value);
            mismatches++;
         end else begin
            want = expected_tokens.pop_front();
            check_field("event_res", want.r.event_res, rsp_event_res);
            check_field("repr_kind", want.r.repr_kind, rsp_repr_kind);
            check_field("value", want.r.value, rsp_value);
            check_field("huffman", want.r.huffman, rsp_huffman);
            check_field("in_value_string", want.r.in_value_string, rsp_in_value_string);
            check_field("out_byte", want.r.out_byte, rsp_out_byte);
            check_field("error_code", want.r.error_code, rsp_error_code);
            check_field("last", want.last, rsp_last);
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      token_type   typed_tok;
      int unsigned spins;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table, reset limit, no idling
      for (int i = 0; i < DIR_N; i++) begin
         send_req(DIR_ROWS[i].data, DIR_ROWS[i].blk_end, !DIR_ROWS[i].typed);
         if (DIR_ROWS[i].typed) begin
            typed_tok                   = '0;
            typed_tok.r.event_res       = DIR_ROWS[i].ev;
            typed_tok.r.value           = DIR_ROWS[i].val;
            typed_tok.r.error_code      = DIR_ROWS[i].err;
            typed_tok.last              = !DIR_ROWS[i].blk_end;
            expected_tokens.insert(expected_tokens.size(), typed_tok);
            if (DIR_ROWS[i].blk_end) begin
               typed_tok                = '0;
               typed_tok.r.event_res    = EV_BLOCK_DONE;
               typed_tok.last           = 1'b1;
               expected_tokens.insert(expected_tokens.size(), typed_tok);
            end
         end
      end

      // zero limit, full rate both sides
      load_limit('0);
      run_random(60);

      // largest limit, sender idles half the time
      load_limit('1);
      send_idle_pct = 50;
      run_random(55);

      // random limit, receiver stalls half the time, one long hold-off
      load_limit($urandom);
      send_idle_pct  = 0;
      recv_stall_pct = 50;
      hold_req++;
      run_random(55);

      // default limit, light idling on both sides, one full drain midway
      load_limit(LIMIT_RESET);
      send_idle_pct  = 12;
      recv_stall_pct = 12;
      run_random(30);
      drain_pipeline();
      run_random(30);

      req_valid <= 1'b0;
      spins = 0;
      while (expected_tokens.size() != 0 && spins < END_SPINS) begin
         @(posedge clock);
         spins++;
      end
      if (expected_tokens.size() != 0) begin
         $display("%0t: %0d expected results never arrived, first event %0d",
                  $time, expected_tokens.size(), expected_tokens[0].r.event_res);
         mismatches++;
      end
      repeat (END_GAP) @(posedge clock);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
